### rtl/mktd_pkg.sv
// ----------------------------------------------------------------------------
// Morse key timing decoder package
// Shared types and fixed constants for the decoder and its output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package mktd_pkg;

  // Width of the dot duration register.
  localparam int unsigned DOT_W       = 11;
  // Width of the character code presented on the output.
  localparam int unsigned CHAR_CODE_W = 8;
  // Dot duration after reset, in ticks.
  localparam int unsigned DOT_RESET   = 60;
  // Ticks the error state is held before returning to idle.
  localparam int unsigned ERROR_HOLD  = 1000;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PRESSED = 2'd1,
    MODE_GAP     = 2'd2,
    MODE_ERROR   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_DOT     = 2'd1,
    KIND_DASH    = 2'd2,
    KIND_UNCLASS = 2'd3
  } kind_e;

  typedef struct packed {
    logic                   char_done;
    logic [CHAR_CODE_W-1:0] char_code;
    kind_e                  element_kind;
    logic                   too_long;
    mode_e                  mode_now;
  } result_t;

endpackage

`default_nettype wire

### rtl/mktd_fsm.sv
// ----------------------------------------------------------------------------
// Morse key timing state machine
// Holds mode, elapsed tick counter and code shift register, and works out the
// result for one tick combinationally from the registered state.
// ----------------------------------------------------------------------------
`default_nettype none

module mktd_fsm #(
  parameter int unsigned CODE_BITS  = 8,
  parameter int unsigned TIMER_BITS = 13
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic                       key_down_i,
  input  wire logic [mktd_pkg::DOT_W-1:0] dot_ms_i,
  output mktd_pkg::result_t               result_o
);

  localparam int unsigned CmpW = (TIMER_BITS + 1 > mktd_pkg::DOT_W + 3) ?
                                 TIMER_BITS + 1 : mktd_pkg::DOT_W + 3;

  mktd_pkg::mode_e       mode_q, mode_d;
  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [CODE_BITS-1:0]  code_q, code_d;

  logic [CmpW-1:0] d2, dot_x, dot3, dot4, dot6, dot8;
  logic            reach_long, is_dot, is_dash, gap_end, hold_over;

  // The counter advances before it is compared, and saturates.
  assign elapsed_inc = (mode_q != mktd_pkg::MODE_IDLE && elapsed_q != '1) ?
                       elapsed_q + 1'b1 : elapsed_q;

  // Durations are compared doubled so that the half-dot thresholds stay integer.
  assign d2    = CmpW'({elapsed_inc, 1'b0});
  assign dot_x = CmpW'(dot_ms_i);
  assign dot3  = (dot_x << 1) + dot_x;
  assign dot4  = dot_x << 2;
  assign dot6  = dot3 << 1;
  assign dot8  = dot_x << 3;

  assign reach_long = (d2 >= dot8);
  assign is_dot     = (d2 < dot3);
  assign is_dash    = (d2 > dot4);
  assign gap_end    = (d2 >= dot6);
  assign hold_over  = (elapsed_inc > TIMER_BITS'(mktd_pkg::ERROR_HOLD));

  // Next state.
  always_comb begin
    mode_d    = mode_q;
    elapsed_d = elapsed_inc;
    code_d    = code_q;
    unique case (mode_q)
      mktd_pkg::MODE_IDLE: begin
        if (key_down_i) begin
          code_d    = CODE_BITS'(1);
          elapsed_d = '0;
          mode_d    = mktd_pkg::MODE_PRESSED;
        end
      end
      mktd_pkg::MODE_PRESSED: begin
        priority if (reach_long) begin
          elapsed_d = '0;
          mode_d    = mktd_pkg::MODE_ERROR;
        end else if (!key_down_i) begin
          if (is_dot) begin
            code_d = {code_q[CODE_BITS-2:0], 1'b0};
          end else if (is_dash) begin
            code_d = {code_q[CODE_BITS-2:0], 1'b1};
          end
          elapsed_d = '0;
          mode_d    = mktd_pkg::MODE_GAP;
        end
      end
      mktd_pkg::MODE_GAP: begin
        priority if (key_down_i) begin
          elapsed_d = '0;
          mode_d    = mktd_pkg::MODE_PRESSED;
        end else if (gap_end) begin
          mode_d = mktd_pkg::MODE_IDLE;
        end
      end
      mktd_pkg::MODE_ERROR: begin
        if (hold_over) begin
          mode_d = mktd_pkg::MODE_IDLE;
        end
      end
      default: mode_d = mktd_pkg::MODE_IDLE;
    endcase
  end

  // Result of this tick.
  always_comb begin
    result_o              = '0;
    result_o.element_kind = mktd_pkg::KIND_NONE;
    result_o.mode_now     = mode_d;
    unique case (mode_q)
      mktd_pkg::MODE_PRESSED: begin
        priority if (reach_long) begin
          result_o.too_long = 1'b1;
        end else if (!key_down_i) begin
          priority if (is_dot) begin
            result_o.element_kind = mktd_pkg::KIND_DOT;
          end else if (is_dash) begin
            result_o.element_kind = mktd_pkg::KIND_DASH;
          end else begin
            result_o.element_kind = mktd_pkg::KIND_UNCLASS;
          end
        end
      end
      mktd_pkg::MODE_GAP: begin
        if (!key_down_i && gap_end) begin
          result_o.char_done = 1'b1;
          result_o.char_code = mktd_pkg::CHAR_CODE_W'(code_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= mktd_pkg::MODE_IDLE;
      elapsed_q <= '0;
      code_q    <= CODE_BITS'(1);
    end else if (step_i) begin
      mode_q    <= mode_d;
      elapsed_q <= elapsed_d;
      code_q    <= code_d;
    end
  end

endmodule

`default_nettype wire

### rtl/mktd_out_reg.sv
// ----------------------------------------------------------------------------
// Morse key timing result register
// Holds one result until the downstream side takes it; a new result may be
// loaded in the same cycle as the held one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module mktd_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire mktd_pkg::result_t  result_i,
  output logic                    free_o,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output mktd_pkg::result_t       result_o
);

  logic              valid_q, valid_d;
  mktd_pkg::result_t data_q;

  assign free_o   = !valid_q || ready_i;
  assign valid_d  = load_i || (valid_q && !ready_i);
  assign valid_o  = valid_q;
  assign result_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

`default_nettype wire

### rtl/morse_key_timing_decoder.sv
// ----------------------------------------------------------------------------
// Morse key timing decoder
// Classifies key presses as dots and dashes against a programmable dot length
// and reports each finished character as a leading-one marked code.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   key_down_i (one tick)
//   out      output     out_valid_o / out_ready_i char_done_o, char_code_o,
//                                                 element_kind_o, too_long_o,
//                                                 mode_now_o
//   cfg      input      cfg_valid_i / cfg_ready_o dot_ms_i
//
// For each accepted tick request the state update and result are formed from
// the state registers and land in the result register at the accepting edge.
// One request per cycle is sustained while out_ready_i is high; a held result
// stalls the input only when it is not taken that cycle.
// Reset leaves the decoder idle, the code at one and the dot length at 60.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_key_timing_decoder #(
  parameter int unsigned CODE_BITS  = 8,
  parameter int unsigned TIMER_BITS = 13
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         key_down_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              char_done_o,
  output logic [mktd_pkg::CHAR_CODE_W-1:0]  char_code_o,
  output logic [1:0]                        element_kind_o,
  output logic                              too_long_o,
  output logic [1:0]                        mode_now_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [mktd_pkg::DOT_W-1:0]   dot_ms_i
);

  logic [mktd_pkg::DOT_W-1:0] dot_ms_q;
  logic                       step;
  logic                       free;
  mktd_pkg::result_t          result, held;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = free;
  assign step        = in_valid_i && free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_ms_q <= mktd_pkg::DOT_W'(mktd_pkg::DOT_RESET);
    end else if (cfg_valid_i) begin
      dot_ms_q <= dot_ms_i;
    end
  end

  mktd_fsm #(
    .CODE_BITS  (CODE_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .key_down_i (key_down_i),
    .dot_ms_i   (dot_ms_q),
    .result_o   (result)
  );

  mktd_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .result_i (result),
    .free_o   (free),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (held)
  );

  assign char_done_o    = held.char_done;
  assign char_code_o    = held.char_code;
  assign element_kind_o = held.element_kind;
  assign too_long_o     = held.too_long;
  assign mode_now_o     = held.mode_now;

endmodule

`default_nettype wire

### tb/morse_key_timing_checker.sv
// ----------------------------------------------------------------------------
// Morse key timing decoder checker
// Watches the tick, result and dot length channels of the decoder, keeps its
// own copy of the decoder state, predicts the result of every accepted tick
// request and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------

module morse_key_timing_checker #(
  parameter int unsigned CODE_BITS  = 8,
  parameter int unsigned TIMER_BITS = 13
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic                             in_ready_i,
  input  wire logic                             key_down_i,
  input  wire logic                             out_valid_i,
  input  wire logic                             out_ready_i,
  input  wire logic                             char_done_i,
  input  wire logic [mktd_pkg::CHAR_CODE_W-1:0] char_code_i,
  input  wire logic [1:0]                       element_kind_i,
  input  wire logic                             too_long_i,
  input  wire logic [1:0]                       mode_now_i,
  input  wire logic                             cfg_valid_i,
  input  wire logic                             cfg_ready_i,
  input  wire logic [mktd_pkg::DOT_W-1:0]       dot_ms_i,
  output int unsigned                           fail_count_o,
  output int unsigned                           pending_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  mktd_pkg::mode_e            key_mode;
  logic [TIMER_BITS-1:0]      tick_count;
  logic [CODE_BITS-1:0]       code_bits;
  logic [mktd_pkg::DOT_W-1:0] dot_len;
  mktd_pkg::result_t          predicted_ticks[$];

  // Advances the decoder copy by one tick and returns the result it must give.
  function automatic mktd_pkg::result_t decode_tick(input logic key);
    mktd_pkg::result_t res;
    int unsigned       twice;
    int unsigned       dot;
    res.char_done    = 1'b0;
    res.char_code    = '0;
    res.element_kind = mktd_pkg::KIND_NONE;
    res.too_long     = 1'b0;
    dot = dot_len;
    if (key_mode != mktd_pkg::MODE_IDLE && tick_count != '1) begin
      tick_count = tick_count + 1'b1;
    end
    // Durations are compared doubled, against doubled thresholds.
    twice = 2 * tick_count;
    case (key_mode)
      mktd_pkg::MODE_IDLE: begin
        if (key) begin
          code_bits  = CODE_BITS'(1);
          tick_count = '0;
          key_mode   = mktd_pkg::MODE_PRESSED;
        end
      end
      mktd_pkg::MODE_PRESSED: begin
        // The overlong check wins over a release on the same tick.
        if (twice >= 8 * dot) begin
          res.too_long = 1'b1;
          tick_count   = '0;
          key_mode     = mktd_pkg::MODE_ERROR;
        end else if (!key) begin
          if (twice < 3 * dot) begin
            res.element_kind = mktd_pkg::KIND_DOT;
            code_bits        = {code_bits[CODE_BITS-2:0], 1'b0};
          end else if (twice > 4 * dot) begin
            res.element_kind = mktd_pkg::KIND_DASH;
            code_bits        = {code_bits[CODE_BITS-2:0], 1'b1};
          end else begin
            res.element_kind = mktd_pkg::KIND_UNCLASS;
          end
          tick_count = '0;
          key_mode   = mktd_pkg::MODE_GAP;
        end
      end
      mktd_pkg::MODE_GAP: begin
        if (key) begin
          tick_count = '0;
          key_mode   = mktd_pkg::MODE_PRESSED;
        end else if (twice >= 6 * dot) begin
          res.char_done = 1'b1;
          res.char_code = mktd_pkg::CHAR_CODE_W'(code_bits);
          key_mode      = mktd_pkg::MODE_IDLE;
        end
      end
      default: begin
        if (tick_count > mktd_pkg::ERROR_HOLD) begin
          key_mode = mktd_pkg::MODE_IDLE;
        end
      end
    endcase
    res.mode_now = key_mode;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    mktd_pkg::result_t got;
    mktd_pkg::result_t want;
    if (!rst_ni) begin
      key_mode     = mktd_pkg::MODE_IDLE;
      tick_count   = '0;
      code_bits    = CODE_BITS'(1);
      dot_len      = mktd_pkg::DOT_W'(mktd_pkg::DOT_RESET);
      predicted_ticks.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // A result taken at this edge always stems from an earlier tick request.
      if (out_valid_i && out_ready_i) begin
        got = {char_done_i, char_code_i, element_kind_i, too_long_i, mode_now_i};
        if (predicted_ticks.size() == 0) begin
          if (fail_count_o < REPORT_LIMIT) begin
            $display("unexpected result: done=%0d code=%02h kind=%0d too_long=%0d mode=%0d",
                     got.char_done, got.char_code, got.element_kind, got.too_long,
                     got.mode_now);
          end
          fail_count_o++;
        end else begin
          want = predicted_ticks.pop_front();
          if (got.char_done !== want.char_done || got.char_code !== want.char_code ||
              got.element_kind !== want.element_kind || got.too_long !== want.too_long ||
              got.mode_now !== want.mode_now) begin
            if (fail_count_o < REPORT_LIMIT) begin
              $display("result mismatch: expected done=%0d code=%02h kind=%0d too_long=%0d mode=%0d",
                       want.char_done, want.char_code, want.element_kind, want.too_long,
                       want.mode_now);
              $display("                 actual   done=%0d code=%02h kind=%0d too_long=%0d mode=%0d",
                       got.char_done, got.char_code, got.element_kind, got.too_long,
                       got.mode_now);
            end
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted_ticks.push_back(decode_tick(key_down_i));
      end
      // A dot length written at this edge applies from the next tick on.
      if (cfg_valid_i && cfg_ready_i) begin
        dot_len = dot_ms_i;
      end
      pending_o = predicted_ticks.size();
    end
  end

endmodule

### tb/morse_key_timing_decoder_tb.sv
// ----------------------------------------------------------------------------
// Morse key timing decoder testbench
// Drives key level ticks and dot length writes into the decoder: directed
// presses at the reset, smallest and extreme dot lengths, then random
// characters at small dot lengths, and finally an overlong press followed by
// part of the error hold, all under random sender bursts and receiver stalls.
// A checker beside the decoder predicts and compares every result.
// ----------------------------------------------------------------------------

module morse_key_timing_decoder_tb;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned RANDOM_TICKS   = 700;
  localparam int unsigned PHASE_TICKS    = 150;
  localparam int unsigned ERROR_TICKS    = 40;
  localparam int unsigned DOT_MAX        = (1 << mktd_pkg::DOT_W) - 1;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC
  } rx_style_e;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  logic                             key_down  = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             char_done;
  logic [mktd_pkg::CHAR_CODE_W-1:0] char_code;
  logic [1:0]                       element_kind;
  logic                             too_long;
  logic [1:0]                       mode_now;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [mktd_pkg::DOT_W-1:0]       dot_ms    = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned dot_setting   = mktd_pkg::DOT_RESET;
  int unsigned burst_left    = 0;
  int unsigned counted_ticks = 0;
  int unsigned phase_start   = 0;
  int unsigned quiet_cycles  = 0;
  bit          first_phase   = 1'b1;
  rx_style_e   rx_style      = RX_FREE;
  int unsigned rx_left       = 0;
  int unsigned rx_phase      = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  morse_key_timing_decoder dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .key_down_i     (key_down),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .char_done_o    (char_done),
    .char_code_o    (char_code),
    .element_kind_o (element_kind),
    .too_long_o     (too_long),
    .mode_now_o     (mode_now),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .dot_ms_i       (dot_ms)
  );

  morse_key_timing_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .key_down_i     (key_down),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .char_done_i    (char_done),
    .char_code_i    (char_code),
    .element_kind_i (element_kind),
    .too_long_i     (too_long),
    .mode_now_i     (mode_now),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .dot_ms_i       (dot_ms),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // The receiver switches between free flow, random stalls and a fixed rhythm.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style = rx_style_e'($urandom_range(0, 2));
      rx_left  = $urandom_range(20, 200);
    end
    rx_left--;
    rx_phase++;
    case (rx_style)
      RX_FREE:   out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      default:   out_ready <= (rx_phase % 5 != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // One tick request; the sender pauses between bursts of random length.
  task automatic send_tick(input logic key, input bit counted);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    key_down <= key;
    burst_left--;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counted) begin
      counted_ticks++;
    end
  endtask

  task automatic key_run(input logic key, input int unsigned len, input bit counted);
    repeat (len) send_tick(key, counted);
  endtask

  // Press lengths lean on the dot, unclassified and dash boundaries.
  function automatic int unsigned pick_press();
    int unsigned top_len;
    int unsigned len;
    top_len = 4 * dot_setting - 1;
    case ($urandom_range(0, 4))
      0:       len = (3 * dot_setting - 1) / 2;
      1:       len = (3 * dot_setting + 1) / 2;
      2:       len = 2 * dot_setting;
      3:       len = 2 * dot_setting + 1;
      default: len = $urandom_range(1, top_len);
    endcase
    if (len < 1) begin
      len = 1;
    end
    if (len > top_len) begin
      len = top_len;
    end
    return len;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 3) == 0) begin
      return 3 * dot_setting - 1;
    end
    return $urandom_range(0, 3 * dot_setting - 1);
  endfunction

  // A character of presses below the overlong limit; the last gap is just long enough to end it.
  task automatic send_char(input int unsigned elems, input bit counted);
    for (int unsigned i = 0; i < elems; i++) begin
      key_run(1'b1, pick_press(), counted);
      key_run(1'b0, 1 + ((i == elems - 1) ? 3 * dot_setting : pick_gap()), counted);
    end
  endtask

  // A press held to four dots, either still down or released on that tick, and
  // then the first part of the error hold with the key moving at random.
  task automatic overrun_press();
    int unsigned hold;
    hold = (dot_setting == 0) ? 1 : 4 * dot_setting;
    if ($urandom_range(0, 1) != 0) begin
      key_run(1'b1, hold + 1, 1'b0);
    end else begin
      key_run(1'b1, hold, 1'b0);
      send_tick(1'b0, 1'b0);
    end
    repeat (ERROR_TICKS) send_tick(1'($urandom_range(0, 1)), 1'b0);
  endtask

  // The dot length only changes once every tick request has its result.
  task automatic write_dot(input int unsigned value);
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    dot_ms    <= mktd_pkg::DOT_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid   <= 1'b0;
    dot_setting = value;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A press of 100 ticks at the dot length left by reset is unclassified.
    key_run(1'b1, 100, 1'b0);
    key_run(1'b0, 1, 1'b0);
    // The dot length may change in the middle of a gap.
    write_dot(2);
    key_run(1'b0, 6, 1'b0);

    // Dot, unclassified press and dash in one character.
    key_run(1'b1, 2, 1'b0);
    key_run(1'b0, 2, 1'b0);
    key_run(1'b1, 4, 1'b0);
    key_run(1'b0, 2, 1'b0);
    key_run(1'b1, 5, 1'b0);
    key_run(1'b0, 7, 1'b0);

    // Short presses at the largest dot length; a shorter dot then ends the gap.
    write_dot(DOT_MAX);
    key_run(1'b1, 3, 1'b0);
    key_run(1'b0, 3, 1'b0);
    key_run(1'b1, 5, 1'b0);
    key_run(1'b0, 1, 1'b0);
    write_dot(1);
    key_run(1'b0, 3, 1'b0);

    write_dot(1200);
    key_run(1'b1, 2, 1'b0);
    key_run(1'b0, 1, 1'b0);
    // With a zero dot a gap ends the character on its first tick.
    write_dot(0);
    key_run(1'b0, 1, 1'b0);

    counted_ticks = 0;
    while (counted_ticks < RANDOM_TICKS) begin
      write_dot(first_phase ? 1 : $urandom_range(1, 8));
      first_phase = 1'b0;
      phase_start = counted_ticks;
      while (counted_ticks - phase_start < PHASE_TICKS && counted_ticks < RANDOM_TICKS) begin
        case ($urandom_range(0, 7))
          0:       key_run(1'b0, $urandom_range(1, 4), 1'b0);
          // Long characters can overflow the code register.
          default: send_char(($urandom_range(0, 3) == 0) ? $urandom_range(7, 11)
                                                         : $urandom_range(1, 6), 1'b1);
        endcase
      end
    end

    // The run closes on an overlong press, sometimes with a zero dot.
    if ($urandom_range(0, 1) != 0) begin
      write_dot(0);
    end
    overrun_press();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mktd_pkg.sv
rtl/mktd_fsm.sv
rtl/mktd_out_reg.sv
rtl/morse_key_timing_decoder.sv
tb/morse_key_timing_checker.sv
tb/morse_key_timing_decoder_tb.sv
